/* design/assert_macros.svh */
// Shared assertion macros for the frame builder checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame builder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame builder check failed");

`endif

/* design/mfb_pkg.sv */
package mfb_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_SLAVE_ADDR = 3'd0;
	localparam logic [2:0] REG_FUNC_SEL   = 3'd1;
	localparam logic [2:0] REG_START_REG  = 3'd2;
	localparam logic [2:0] REG_REG_COUNT  = 3'd3;
	localparam logic [2:0] REG_FRAME_FMT  = 3'd4;

	// frame formats
	localparam logic [1:0] FMT_RTU   = 2'd0;
	localparam logic [1:0] FMT_ASCII = 2'd1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// microprogram layout
	localparam int unsigned PC_W       = 6;
	localparam logic [PC_W-1:0] PC_DISPATCH  = 6'd0;
	localparam logic [PC_W-1:0] PC_RTU       = 6'd1;
	localparam logic [PC_W-1:0] PC_ASCII     = 6'd9;
	localparam logic [PC_W-1:0] PC_TCP       = 6'd26;

	typedef enum logic [3:0] {
		SRC_LIT    = 4'd0,
		SRC_SLAVE  = 4'd1,
		SRC_FUNC   = 4'd2,
		SRC_REG_HI = 4'd3,
		SRC_REG_LO = 4'd4,
		SRC_CNT_HI = 4'd5,
		SRC_CNT_LO = 4'd6,
		SRC_CRC_LO = 4'd7,
		SRC_CRC_HI = 4'd8,
		SRC_LRC    = 4'd9
	} src_t;

	typedef enum logic [1:0] {
		HEX_RAW = 2'd0,
		HEX_HI  = 2'd1,
		HEX_LO  = 2'd2
	} hex_t;

	// one microcode word
	typedef struct packed {
		logic       emit;      // step puts a byte into the output register
		src_t       src;
		hex_t       hex;
		logic       acc;       // fold source byte into CRC and LRC
		logic       last;
		logic       stop;      // end of program
		logic       dispatch;  // jump on frame format
		logic [7:0] lit;
	} uword_t;

	typedef struct packed {
		logic       start;     // a frame request was taken this cycle
		logic       exec;      // current word executes this cycle
		uword_t     word;
	} step_t;

	typedef struct packed {
		logic [7:0]  slave_address;
		logic [2:0]  function_select;
		logic [15:0] start_register;
		logic [15:0] register_count;
		logic [1:0]  frame_format;
	} cfg_t;

	function automatic logic [7:0] func_code(input logic [2:0] sel);
		logic [7:0] code;
		case (sel)
			3'd0:    code = 8'h01;
			3'd1:    code = 8'h03;
			3'd2:    code = 8'h05;
			3'd3:    code = 8'h06;
			default: code = 8'h10;
		endcase
		return code;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = 8'h30 + {4'h0, nib};
		end else begin
			ch = 8'h37 + {4'h0, nib};
		end
		return ch;
	endfunction

	// one byte of the reflected CRC-16, bit at a time
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* design/modbus_request_frame_builder_core.sv */
// Modbus request frame builder. Each accepted request with request = 1 makes the
// block emit one whole Modbus request frame on the output channel, one byte per
// transfer, with last_byte marking the final byte; a request with request = 0 is
// taken and produces nothing. The frame uses the configured slave address,
// function code (select 0..4 gives 01,03,05,06,10, higher values give 10), start
// register and count, and the format register: 0 RTU (six bytes then CRC-16 low
// byte first, 8 bytes), 1 ASCII (':', hex pairs, LRC pair, CR LF, 17 characters),
// 2 or 3 TCP (MBAP header 00 01 00 00 00 06 then six bytes, 12 bytes). A small
// microprogram in ROM steps through the frame: a dispatch step on the format,
// then one byte per cycle while the output is taken. CRC and LRC are
// accumulated as the data bytes go out, so the check bytes follow directly.
// in_ready is low from the request until the final byte has entered the output
// register; the next request can be taken while that byte still waits. Write
// configuration only between frames.
module modbus_request_frame_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        request,
	// frame byte channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);

	mfb_pkg::cfg_t  cfg_q;
	mfb_pkg::step_t step;
	logic           out_free;

	// configuration registers; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address   <= 8'd1;
			cfg_q.function_select <= 3'd1;
			cfg_q.start_register  <= 16'd0;
			cfg_q.register_count  <= 16'd1;
			cfg_q.frame_format    <= mfb_pkg::FMT_RTU;
		end else if (cfg_we) begin
			case (cfg_addr)
				mfb_pkg::REG_SLAVE_ADDR: cfg_q.slave_address   <= cfg_wdata[7:0];
				mfb_pkg::REG_FUNC_SEL:   cfg_q.function_select <= cfg_wdata[2:0];
				mfb_pkg::REG_START_REG:  cfg_q.start_register  <= cfg_wdata;
				mfb_pkg::REG_REG_COUNT:  cfg_q.register_count  <= cfg_wdata;
				mfb_pkg::REG_FRAME_FMT:  cfg_q.frame_format    <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// step counter and microcode ROM
	mfb_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.request      (request),
		.frame_format (cfg_q.frame_format),
		.out_free     (out_free),
		.step         (step)
	);

	// byte selection, hex encoding, CRC/LRC and output register
	mfb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.step       (step),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

/* design/mfb_rom.sv */
module mfb_rom (
	input  logic [mfb_pkg::PC_W-1:0] pc,
	output mfb_pkg::uword_t          word
);

	function automatic mfb_pkg::uword_t uw(
		input logic          emit,
		input mfb_pkg::src_t src,
		input mfb_pkg::hex_t hex,
		input logic          acc,
		input logic          last,
		input logic          stop,
		input logic          dispatch,
		input logic [7:0]    lit
	);
		mfb_pkg::uword_t w;
		w.emit     = emit;
		w.src      = src;
		w.hex      = hex;
		w.acc      = acc;
		w.last     = last;
		w.stop     = stop;
		w.dispatch = dispatch;
		w.lit      = lit;
		return w;
	endfunction

	always_comb begin
		case (pc)
			// dispatch on frame format
			6'd0:  word = uw(1'b0, mfb_pkg::SRC_LIT, mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
			// RTU
			6'd1:  word = uw(1'b1, mfb_pkg::SRC_SLAVE,  mfb_pkg::HEX_RAW, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd2:  word = uw(1'b1, mfb_pkg::SRC_FUNC,   mfb_pkg::HEX_RAW, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd3:  word = uw(1'b1, mfb_pkg::SRC_REG_HI, mfb_pkg::HEX_RAW, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd4:  word = uw(1'b1, mfb_pkg::SRC_REG_LO, mfb_pkg::HEX_RAW, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd5:  word = uw(1'b1, mfb_pkg::SRC_CNT_HI, mfb_pkg::HEX_RAW, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd6:  word = uw(1'b1, mfb_pkg::SRC_CNT_LO, mfb_pkg::HEX_RAW, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd7:  word = uw(1'b1, mfb_pkg::SRC_CRC_LO, mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd8:  word = uw(1'b1, mfb_pkg::SRC_CRC_HI, mfb_pkg::HEX_RAW, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00);
			// ASCII
			6'd9:  word = uw(1'b1, mfb_pkg::SRC_LIT,    mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h3A);
			6'd10: word = uw(1'b1, mfb_pkg::SRC_SLAVE,  mfb_pkg::HEX_HI,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd11: word = uw(1'b1, mfb_pkg::SRC_SLAVE,  mfb_pkg::HEX_LO,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd12: word = uw(1'b1, mfb_pkg::SRC_FUNC,   mfb_pkg::HEX_HI,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd13: word = uw(1'b1, mfb_pkg::SRC_FUNC,   mfb_pkg::HEX_LO,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd14: word = uw(1'b1, mfb_pkg::SRC_REG_HI, mfb_pkg::HEX_HI,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd15: word = uw(1'b1, mfb_pkg::SRC_REG_HI, mfb_pkg::HEX_LO,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd16: word = uw(1'b1, mfb_pkg::SRC_REG_LO, mfb_pkg::HEX_HI,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd17: word = uw(1'b1, mfb_pkg::SRC_REG_LO, mfb_pkg::HEX_LO,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd18: word = uw(1'b1, mfb_pkg::SRC_CNT_HI, mfb_pkg::HEX_HI,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd19: word = uw(1'b1, mfb_pkg::SRC_CNT_HI, mfb_pkg::HEX_LO,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd20: word = uw(1'b1, mfb_pkg::SRC_CNT_LO, mfb_pkg::HEX_HI,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd21: word = uw(1'b1, mfb_pkg::SRC_CNT_LO, mfb_pkg::HEX_LO,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd22: word = uw(1'b1, mfb_pkg::SRC_LRC,    mfb_pkg::HEX_HI,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd23: word = uw(1'b1, mfb_pkg::SRC_LRC,    mfb_pkg::HEX_LO,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd24: word = uw(1'b1, mfb_pkg::SRC_LIT,    mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h0D);
			6'd25: word = uw(1'b1, mfb_pkg::SRC_LIT,    mfb_pkg::HEX_RAW, 1'b0, 1'b1, 1'b1, 1'b0, 8'h0A);
			// TCP: MBAP header then PDU
			6'd26: word = uw(1'b1, mfb_pkg::SRC_LIT,    mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd27: word = uw(1'b1, mfb_pkg::SRC_LIT,    mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h01);
			6'd28: word = uw(1'b1, mfb_pkg::SRC_LIT,    mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd29: word = uw(1'b1, mfb_pkg::SRC_LIT,    mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd30: word = uw(1'b1, mfb_pkg::SRC_LIT,    mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd31: word = uw(1'b1, mfb_pkg::SRC_LIT,    mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h06);
			6'd32: word = uw(1'b1, mfb_pkg::SRC_SLAVE,  mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd33: word = uw(1'b1, mfb_pkg::SRC_FUNC,   mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd34: word = uw(1'b1, mfb_pkg::SRC_REG_HI, mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd35: word = uw(1'b1, mfb_pkg::SRC_REG_LO, mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd36: word = uw(1'b1, mfb_pkg::SRC_CNT_HI, mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
			6'd37: word = uw(1'b1, mfb_pkg::SRC_CNT_LO, mfb_pkg::HEX_RAW, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00);
			// unused addresses just end the program
			default: word = uw(1'b0, mfb_pkg::SRC_LIT, mfb_pkg::HEX_RAW, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
		endcase
	end

endmodule

/* design/mfb_seq.sv */
module mfb_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                request,
	input  logic [1:0]          frame_format,
	input  logic                out_free,
	output mfb_pkg::step_t      step
);

	logic                    busy_q;
	logic [mfb_pkg::PC_W-1:0] pc_q;
	logic [mfb_pkg::PC_W-1:0] entry;
	mfb_pkg::uword_t         word;
	logic                    take;
	logic                    exec;

	mfb_rom u_rom (
		.pc   (pc_q),
		.word (word)
	);

	assign in_ready = !busy_q;
	assign take     = in_valid && in_ready && request;
	// emitting words wait for room in the output register
	assign exec     = busy_q && (!word.emit || out_free);

	always_comb begin
		case (frame_format)
			mfb_pkg::FMT_RTU:   entry = mfb_pkg::PC_RTU;
			mfb_pkg::FMT_ASCII: entry = mfb_pkg::PC_ASCII;
			default:            entry = mfb_pkg::PC_TCP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= mfb_pkg::PC_DISPATCH;
		end else if (take) begin
			busy_q <= 1'b1;
			pc_q   <= mfb_pkg::PC_DISPATCH;
		end else if (exec) begin
			if (word.stop) begin
				busy_q <= 1'b0;
			end else if (word.dispatch) begin
				pc_q <= entry;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	assign step.start = take;
	assign step.exec  = exec;
	assign step.word  = word;

endmodule

/* design/mfb_dp.sv */
module mfb_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  mfb_pkg::cfg_t  cfg,
	input  mfb_pkg::step_t step,
	output logic           out_free,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     frame_byte,
	output logic           last_byte
);

	logic [15:0] crc_q;
	logic [7:0]  sum_q;
	logic [7:0]  src_byte;
	logic [7:0]  nxt_byte;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;

	always_comb begin
		case (step.word.src)
			mfb_pkg::SRC_LIT:    src_byte = step.word.lit;
			mfb_pkg::SRC_SLAVE:  src_byte = cfg.slave_address;
			mfb_pkg::SRC_FUNC:   src_byte = mfb_pkg::func_code(cfg.function_select);
			mfb_pkg::SRC_REG_HI: src_byte = cfg.start_register[15:8];
			mfb_pkg::SRC_REG_LO: src_byte = cfg.start_register[7:0];
			mfb_pkg::SRC_CNT_HI: src_byte = cfg.register_count[15:8];
			mfb_pkg::SRC_CNT_LO: src_byte = cfg.register_count[7:0];
			mfb_pkg::SRC_CRC_LO: src_byte = crc_q[7:0];
			mfb_pkg::SRC_CRC_HI: src_byte = crc_q[15:8];
			mfb_pkg::SRC_LRC:    src_byte = 8'h00 - sum_q;
			default:             src_byte = 8'h00;
		endcase
	end

	always_comb begin
		case (step.word.hex)
			mfb_pkg::HEX_HI: nxt_byte = mfb_pkg::hex_char(src_byte[7:4]);
			mfb_pkg::HEX_LO: nxt_byte = mfb_pkg::hex_char(src_byte[3:0]);
			default:         nxt_byte = src_byte;
		endcase
	end

	// check accumulators
	always_ff @(posedge clk) begin
		if (step.start) begin
			crc_q <= mfb_pkg::CRC_INIT;
			sum_q <= 8'h00;
		end else if (step.exec && step.word.acc) begin
			crc_q <= mfb_pkg::crc16_byte(crc_q, src_byte);
			sum_q <= sum_q + src_byte;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.exec && step.word.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.exec && step.word.emit) begin
			byte_q <= nxt_byte;
			last_q <= step.word.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

endmodule

/* design/mfb_checker.sv */
`include "assert_macros.svh"

module mfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        request,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  frame_byte,
	input logic        last_byte
);

	// a stalled byte holds
	`MFB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(frame_byte) && $stable(last_byte))

	// a real request starts a frame, so no second request straight after it
	`MFB_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready && request, !in_ready)

	// an empty request leaves the block idle
	`MFB_ASSERT_NEXT(a_empty_req_idle, clk, arst_n, in_valid && in_ready && !request, in_ready)

	// while a mid-frame byte is pending, the frame is still being built
	`MFB_ASSERT_NOW(a_mid_frame_busy, clk, arst_n, out_valid && !last_byte, !in_ready)

endmodule

bind modbus_request_frame_builder_core mfb_checker u_mfb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.request    (request),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.frame_byte (frame_byte),
	.last_byte  (last_byte)
);
